FILE: rtl/nll_pkg.sv
// Shared types, constants and helpers for the nonlinear ladder lowpass.
// Used by the controller, the datapath and the top level; no dependencies.
package nll_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_STAGES  = 4;
    localparam int STAGE_IDX_W = 2;
    localparam int DIV_STEPS   = 24;
    localparam int DIV_CNT_W   = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0]          GAIN_MAX   = 23'd4194304;
    localparam logic [GAIN_W-1:0]          RES_MAX    = 23'd4194304;
    localparam logic signed [SAMPLE_W-1:0] Q_ONE      = 24'sd1048576;
    localparam logic signed [SAMPLE_W-1:0] S24_MAX    = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S24_MIN    = 24'sh800000;

    // Reciprocal of the thermal voltage and the rational tanh coefficients.
    localparam logic signed [32:0] INV_TV = 33'sd1680410;
    localparam logic signed [32:0] TC_A   = 33'sd2574786;
    localparam logic signed [32:0] TC_B   = 33'sd936619;
    localparam logic signed [32:0] TC_C   = 33'sd861119;
    localparam logic signed [32:0] TC_D   = 33'sd2563838;
    localparam logic signed [32:0] TC_E   = 33'sd854215;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DRV,
        OP_XIN,
        OP_TSTEP,
        OP_DSTEP,
        OP_TDONE,
        OP_ERR,
        OP_UPD,
        OP_OUT
    } op_t;

    // Steps of the tanh approximation ahead of the division.
    typedef enum logic [3:0] {
        TS_SCALE,
        TS_SQ,
        TS_NUM0,
        TS_TB,
        TS_NUM1,
        TS_EX,
        TS_INNER,
        TS_DEN,
        TS_PROD
    } tstep_t;

    typedef struct packed {
        op_t                    op;
        tstep_t                 tstep;
        logic [STAGE_IDX_W-1:0] stage;
        logic                   to_input;
        logic                   load_in;
    } cmd_t;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 64'(S24_MAX)) begin
            r = S24_MAX;
        end else if (v < 64'(S24_MIN)) begin
            r = S24_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/nll_ctrl.sv
// Sequencing state machine of the ladder lowpass: walks drive, passes,
// tanh steps, division and stage updates. Depends on nll_pkg.
module nll_ctrl
    import nll_pkg::*;
#(
    parameter int OVERSAMPLE = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    localparam int PASS_W = $clog2(OVERSAMPLE + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLEAR = 10'b0000000010,
        ST_DRV   = 10'b0000000100,
        ST_XIN   = 10'b0000001000,
        ST_TANH  = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_TDONE = 10'b0001000000,
        ST_ERR   = 10'b0010000000,
        ST_UPD   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    tstep_t                 tstep_reg, tstep_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STAGE_IDX_W-1:0] stage_reg, stage_next;
    logic [PASS_W-1:0]      pass_reg, pass_next;
    logic                   to_input_reg, to_input_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        tstep_next    = tstep_reg;
        cnt_next      = cnt_reg;
        stage_next    = stage_reg;
        pass_next     = pass_reg;
        to_input_next = to_input_reg;
        m_valid_next  = m_valid_reg;
        cmd           = '{op: OP_NONE, tstep: tstep_reg, stage: stage_reg,
                          to_input: to_input_reg, load_in: accept};
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.op     = OP_CLEAR;
                state_next = ST_DRV;
            end
            ST_DRV: begin
                cmd.op     = OP_DRV;
                pass_next  = '0;
                state_next = ST_XIN;
            end
            ST_XIN: begin
                cmd.op        = OP_XIN;
                to_input_next = 1'b1;
                tstep_next    = TS_SCALE;
                state_next    = ST_TANH;
            end
            ST_TANH: begin
                cmd.op = OP_TSTEP;
                if (tstep_reg == TS_PROD) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    tstep_next = tstep_t'(tstep_reg + 4'd1);
                end
            end
            ST_DIV: begin
                cmd.op   = OP_DSTEP;
                cnt_next = DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_TDONE;
                end
            end
            ST_TDONE: begin
                cmd.op = OP_TDONE;
                if (to_input_reg) begin
                    to_input_next = 1'b0;
                    stage_next    = '0;
                    state_next    = ST_ERR;
                end else if (stage_reg != STAGE_IDX_W'(NUM_STAGES - 1)) begin
                    stage_next = STAGE_IDX_W'(stage_reg + 1'b1);
                    state_next = ST_ERR;
                end else if (pass_reg != PASS_W'(OVERSAMPLE - 1)) begin
                    pass_next  = PASS_W'(pass_reg + 1'b1);
                    state_next = ST_XIN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_ERR: begin
                cmd.op     = OP_ERR;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.op     = OP_UPD;
                tstep_next = TS_SCALE;
                state_next = ST_TANH;
            end
            ST_OUT: begin
                // Hold the finished sample until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tstep_reg    <= TS_SCALE;
            cnt_reg      <= '0;
            stage_reg    <= '0;
            pass_reg     <= '0;
            to_input_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tstep_reg    <= tstep_next;
            cnt_reg      <= cnt_next;
            stage_reg    <= stage_next;
            pass_reg     <= pass_next;
            to_input_reg <= to_input_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

FILE: rtl/nll_dp.sv
// Datapath of the ladder lowpass: configuration and stage registers, one
// shared multiplier, the tanh step registers and a bit-serial divider.
// Depends on nll_pkg.
module nll_dp
    import nll_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_W-1:0]        cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       voice_reset,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    logic [GAIN_W-1:0]          step_reg, res_reg;
    logic signed [SAMPLE_W-1:0] drive_reg;
    logic signed [SAMPLE_W-1:0] in_reg;
    logic                       vr_reg;
    logic signed [SAMPLE_W-1:0] drv_reg, tin_reg, t_reg, e_reg, out_reg;
    logic signed [SAMPLE_W-1:0] v_reg    [NUM_STAGES];
    logic signed [SAMPLE_W-1:0] prev_reg [NUM_STAGES];
    logic signed [SAMPLE_W-1:0] th_reg   [NUM_STAGES];

    logic signed [24:0] x_reg, ex_reg;
    logic [28:0]        sq_reg, inner_reg;
    logic [31:0]        num_reg;
    logic [23:0]        tb_reg;
    logic [35:0]        den_reg;
    logic               neg_reg;
    logic [35:0]        rem_reg;
    logic [23:0]        dvd_reg, quo_reg;

    logic [GAIN_W-1:0]  g, res;
    logic signed [24:0] xabs;
    logic [23:0]        a;
    logic signed [24:0] diff;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod, r20, r22;
    logic signed [29:0] inner_sum;
    logic [56:0]        prod_abs;
    logic [36:0]        cand;
    logic               ge;
    logic signed [SAMPLE_W-1:0] q_signed, v_new;

    assign g    = (step_reg > GAIN_MAX) ? GAIN_MAX : step_reg;
    assign res  = (res_reg > RES_MAX) ? RES_MAX : res_reg;
    assign xabs = x_reg[24] ? -x_reg : x_reg;
    assign a    = xabs[23:0];
    assign diff = (cmd.stage == '0)
                ? (25'(t_reg) + 25'(th_reg[0]))
                : (25'(th_reg[cmd.stage - 1'b1]) - 25'(th_reg[cmd.stage]));

    // Operand selection for the single shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority case (cmd.op)
            OP_DRV: begin
                mul_a = 33'(in_reg);
                mul_b = 33'(drive_reg);
            end
            OP_XIN: begin
                mul_a = $signed({10'd0, res});
                mul_b = 33'(v_reg[NUM_STAGES-1]);
            end
            OP_ERR: begin
                mul_a = $signed({10'd0, g});
                mul_b = 33'(diff);
            end
            OP_TSTEP: begin
                unique case (cmd.tstep)
                    TS_SCALE: begin mul_a = 33'(tin_reg);  mul_b = INV_TV; end
                    TS_SQ:    begin mul_a = 33'(x_reg);    mul_b = 33'(x_reg); end
                    TS_NUM0:  begin mul_a = TC_A;          mul_b = $signed({9'd0, a}); end
                    TS_TB:    begin mul_a = TC_C;          mul_b = $signed({9'd0, a}); end
                    TS_NUM1:  begin
                        mul_a = $signed({4'd0, sq_reg});
                        mul_b = $signed({9'd0, tb_reg});
                    end
                    TS_EX:    begin mul_a = TC_E;          mul_b = 33'(x_reg); end
                    TS_INNER: begin mul_a = 33'(ex_reg);   mul_b = $signed({9'd0, a}); end
                    TS_DEN:   begin
                        mul_a = 33'(TC_D + $signed({4'd0, sq_reg}));
                        mul_b = $signed({4'd0, inner_reg});
                    end
                    TS_PROD:  begin mul_a = 33'(x_reg);    mul_b = $signed({1'b0, num_reg}); end
                    default:  begin mul_a = '0;            mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign r20       = (prod + 66'sd524288) >>> 20;
    assign r22       = (prod + 66'sd2097152) >>> 22;
    assign inner_sum = 30'(x_reg) + r20[29:0];
    assign prod_abs  = prod[56] ? 57'(-prod[56:0]) : prod[56:0];
    assign cand      = {rem_reg, dvd_reg[23]};
    assign ge        = (cand >= {1'b0, den_reg});
    assign q_signed  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign v_new     = sat24(64'(v_reg[cmd.stage]) + 64'(e_reg) + 64'(prev_reg[cmd.stage]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            res_reg   <= '0;
            drive_reg <= Q_ONE;
            for (int i = 0; i < NUM_STAGES; i++) begin
                v_reg[i]    <= '0;
                prev_reg[i] <= '0;
                th_reg[i]   <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_STEP_GAIN:  step_reg  <= cfg_wr_data[GAIN_W-1:0];
                    REG_RES_GAIN:   res_reg   <= cfg_wr_data[GAIN_W-1:0];
                    REG_DRIVE_GAIN: drive_reg <= $signed(cfg_wr_data);
                    default: ;
                endcase
            end
            priority case (cmd.op)
                OP_CLEAR: begin
                    if (vr_reg) begin
                        for (int i = 0; i < NUM_STAGES; i++) begin
                            v_reg[i]    <= '0;
                            prev_reg[i] <= '0;
                            th_reg[i]   <= '0;
                        end
                    end
                end
                OP_TDONE: begin
                    if (!cmd.to_input) begin
                        th_reg[cmd.stage] <= q_signed;
                    end
                end
                OP_UPD: begin
                    v_reg[cmd.stage]    <= v_new;
                    prev_reg[cmd.stage] <= e_reg;
                end
                default: ;
            endcase
        end
    end

    // Working registers carry no control meaning and need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= in_sample;
            vr_reg <= voice_reset;
        end
        priority case (cmd.op)
            OP_DRV: drv_reg <= sat24(64'(r20));
            OP_XIN: tin_reg <= sat24(64'(drv_reg) + 64'(r20));
            OP_ERR: e_reg   <= (cmd.stage == '0) ? sat24(-64'(r22)) : sat24(64'(r22));
            OP_UPD: tin_reg <= v_new;
            OP_OUT: out_reg <= v_reg[NUM_STAGES-1];
            OP_TDONE: begin
                if (cmd.to_input) begin
                    t_reg <= q_signed;
                end
            end
            OP_DSTEP: begin
                rem_reg <= ge ? 36'(cand - {1'b0, den_reg}) : cand[35:0];
                dvd_reg <= {dvd_reg[22:0], 1'b0};
                quo_reg <= {quo_reg[22:0], ge};
            end
            OP_TSTEP: begin
                unique case (cmd.tstep)
                    TS_SCALE: x_reg   <= r20[24:0];
                    TS_SQ:    sq_reg  <= r20[28:0];
                    TS_NUM0:  num_reg <= 32'(r20[31:0] + 32'(TC_A));
                    TS_TB:    tb_reg  <= 24'(r20[23:0] + 24'(TC_B));
                    TS_NUM1:  num_reg <= 32'(num_reg + r20[31:0]);
                    TS_EX:    ex_reg  <= r20[24:0];
                    TS_INNER: inner_reg <= inner_sum[29] ? 29'(-inner_sum) : inner_sum[28:0];
                    TS_DEN:   den_reg <= 36'(r20[35:0] + 36'(TC_D));
                    TS_PROD: begin
                        // The quotient stays below 2^24, so the upper dividend
                        // bits start out below the divisor.
                        neg_reg <= x_reg[24];
                        rem_reg <= {4'd0, prod_abs[55:24]};
                        dvd_reg <= prod_abs[23:0];
                        quo_reg <= '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign out_sample = out_reg;

endmodule

FILE: rtl/nonlinear_ladder_lowpass.sv
// Top level of the four-pole nonlinear ladder lowpass filter.
// Joins nll_ctrl and nll_dp; depends on nll_pkg.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_in_sample, s_voice_reset
//   m_        out        m_valid/m_ready    m_out_sample
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// A sample is cleared and driven, then each of OVERSAMPLE passes runs five
// tanh evaluations through the 24-step serial divider, plus the ladder input
// and an error and update step per stage.
// One transaction is worked on at a time; the output register lets the next
// input transaction be taken while a result waits for m_ready.
// Reset is synchronous on aresetn, clears all stage state and sets the
// configuration registers to their reset values.
module nonlinear_ladder_lowpass
    import nll_pkg::*;
#(
    parameter int OVERSAMPLE = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_in_sample,
    input  logic                       s_voice_reset,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_sample,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_W-1:0]        cfg_wr_data
);

    cmd_t cmd;

    nll_ctrl #(
        .OVERSAMPLE(OVERSAMPLE)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    nll_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (s_in_sample),
        .voice_reset (s_voice_reset),
        .out_sample  (m_out_sample)
    );

    // An accepted transaction keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after a transaction");

    // A new result appears only as the controller returns to idle.
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while a transaction is in progress");

    // The output is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

endmodule

FILE: dv/nonlinear_ladder_lowpass_tb.sv
// Self-checking testbench for the nonlinear ladder lowpass filter.
// Drives random, directed samples; checks outputs against a fixed-point predictor or known values.
// Depends on nll_pkg and nonlinear_ladder_lowpass.
`timescale 1ns / 100ps

module nonlinear_ladder_lowpass_tb;
    import nll_pkg::*;

    localparam int  ITEMS_PER_PHASE = 290;
    localparam int  NUM_PHASES      = 6;
    localparam int  HOLDOFF_CYCLES  = 1500;
    localparam int  WATCHDOG_LIMIT  = 30000;
    localparam int  DIR_ROWS        = 22;
    localparam int  DIR_KNOWN_ROWS  = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_in_sample = '0;
    logic                       s_voice_reset = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [SAMPLE_W-1:0]        cfg_wr_data = '0;

    nonlinear_ladder_lowpass uut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Filter state mirrored by the predictor.
    longint volt[NUM_STAGES];
    longint prev_delta[NUM_STAGES];
    longint stage_th[NUM_STAGES];
    logic [GAIN_W-1:0]          step_gain_q;
    logic [GAIN_W-1:0]          res_gain_q;
    logic signed [SAMPLE_W-1:0] drive_gain_q;

    logic signed [SAMPLE_W-1:0] expected_samples[$];
    int  mismatches = 0;
    bit  typed_known = 1'b0;
    logic signed [SAMPLE_W-1:0] typed_value = '0;
    bit  sender_calm = 1'b0;
    bit  receiver_calm = 1'b0;
    bit  hold_request = 1'b0;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       voice_rst;
        bit                         known;
        logic signed [SAMPLE_W-1:0] outcome;
    } stim_row_t;

    stim_row_t dir_rows[DIR_ROWS] = '{
        // Reset configuration has zero step gain, so the ladder never moves.
        '{24'sh000000, 1'b0, 1'b1, 24'sh000000},
        '{24'sh7FFFFF, 1'b0, 1'b1, 24'sh000000},
        '{24'sh800000, 1'b1, 1'b1, 24'sh000000},
        '{24'sh000001, 1'b0, 1'b1, 24'sh000000},
        '{24'shFFFFFF, 1'b1, 1'b1, 24'sh000000},
        '{24'sh555555, 1'b0, 1'b1, 24'sh000000},
        '{24'sh7FFFFF, 1'b0, 1'b0, 24'sh0},
        '{24'sh7FFFFF, 1'b0, 1'b0, 24'sh0},
        '{24'sh7FFFFF, 1'b0, 1'b0, 24'sh0},
        '{24'sh800000, 1'b0, 1'b0, 24'sh0},
        '{24'sh800000, 1'b0, 1'b0, 24'sh0},
        '{24'sh800000, 1'b1, 1'b0, 24'sh0},
        '{24'sh100000, 1'b0, 1'b0, 24'sh0},
        '{24'shF00000, 1'b0, 1'b0, 24'sh0},
        '{24'sh000000, 1'b0, 1'b0, 24'sh0},
        '{24'sh000000, 1'b1, 1'b0, 24'sh0},
        '{24'sh2AAAAA, 1'b0, 1'b0, 24'sh0},
        '{24'shD55555, 1'b0, 1'b0, 24'sh0},
        '{24'sh7FFFFF, 1'b1, 1'b0, 24'sh0},
        '{24'sh000001, 1'b0, 1'b0, 24'sh0},
        '{24'shFFFFFF, 1'b0, 1'b0, 24'sh0},
        '{24'sh000000, 1'b0, 1'b0, 24'sh0}
    };

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    // Product rounded half up back to the given fraction width.
    function automatic longint mul_round(longint a, longint b, int shift);
        return (a * b + (64'sd1 <<< (shift - 1))) >>> shift;
    endfunction

    function automatic longint tanh_approx(longint x);
        longint mag, sq, num, inner, den;
        mag = (x < 0) ? -x : x;
        sq = mul_round(x, x, 20);
        num = longint'(TC_A) + mul_round(longint'(TC_A), mag, 20)
            + mul_round(sq, longint'(TC_B) + mul_round(longint'(TC_C), mag, 20), 20);
        inner = x + mul_round(mul_round(longint'(TC_E), x, 20), mag, 20);
        if (inner < 0) begin
            inner = -inner;
        end
        den = longint'(TC_D) + mul_round(longint'(TC_D) + sq, inner, 20);
        return (x * num) / den;
    endfunction

    function automatic longint stage_tanh_of(longint v);
        return tanh_approx(mul_round(v, longint'(INV_TV), 20));
    endfunction

    function automatic void clear_ladder();
        for (int i = 0; i < NUM_STAGES; i++) begin
            volt[i] = 0;
            prev_delta[i] = 0;
            stage_th[i] = 0;
        end
    endfunction

    function automatic void advance_stage(int i, longint delta);
        volt[i] = clamp24(volt[i] + delta + prev_delta[i]);
        prev_delta[i] = delta;
        stage_th[i] = stage_tanh_of(volt[i]);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        logic signed [SAMPLE_W-1:0] smp, logic voice_rst);
        longint g, res, drv, xin, t;
        g = (step_gain_q > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(step_gain_q);
        res = (res_gain_q > RES_MAX) ? longint'(RES_MAX) : longint'(res_gain_q);
        if (voice_rst) begin
            clear_ladder();
        end
        drv = clamp24(mul_round(longint'(smp), longint'(drive_gain_q), 20));
        for (int pass = 0; pass < 2; pass++) begin
            xin = clamp24(drv + mul_round(res, volt[NUM_STAGES-1], 20));
            t = stage_tanh_of(xin);
            advance_stage(0, clamp24(-mul_round(g, t + stage_th[0], 22)));
            for (int i = 1; i < NUM_STAGES; i++) begin
                advance_stage(i, clamp24(mul_round(g, stage_th[i-1] - stage_th[i], 22)));
            end
        end
        return volt[NUM_STAGES-1][SAMPLE_W-1:0];
    endfunction

    // Input monitor: predict at each accepted input transaction.
    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] predicted;
        if (aresetn && s_valid && s_ready) begin
            predicted = filter_sample(s_in_sample, s_voice_reset);
            expected_samples.push_back(typed_known ? typed_value : predicted);
        end
    end

    // Output monitor.
    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected output transaction: out_sample=%0d", m_out_sample);
                end
            end else begin
                want = expected_samples.pop_front();
                if (m_out_sample !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("out_sample mismatch: expected %0d, actual %0d",
                                 want, m_out_sample);
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!receiver_calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_sample(logic signed [SAMPLE_W-1:0] smp, logic voice_rst,
                               bit known, logic signed [SAMPLE_W-1:0] outcome);
        if (!sender_calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_sample <= smp;
        s_voice_reset <= voice_rst;
        typed_known <= known;
        typed_value <= outcome;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic drain_filter();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        unique case (idx)
            REG_STEP_GAIN:  step_gain_q = data[GAIN_W-1:0];
            REG_RES_GAIN:   res_gain_q = data[GAIN_W-1:0];
            REG_DRIVE_GAIN: drive_gain_q = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_filter(logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] res,
                              logic [SAMPLE_W-1:0] drive);
        write_reg(REG_STEP_GAIN, g);
        write_reg(REG_RES_GAIN, res);
        write_reg(REG_DRIVE_GAIN, drive);
        write_reg(REG_UNUSED, SAMPLE_W'($urandom()));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        unique case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2: return SAMPLE_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    logic [SAMPLE_W-1:0] phase_cfg[NUM_PHASES][3] = '{
        '{24'd300000,  24'd1048576, 24'd1048576},
        '{24'd4194304, 24'd4194304, 24'h7FFFFF},
        '{24'h7FFFFF,  24'h7FFFFF,  24'h800000},
        '{24'd0,       24'd0,       24'd1048576},
        '{24'd1500000, 24'd3000000, 24'd2097152},
        '{24'd700000,  24'd4194304, 24'hF00000}
    };

    initial begin
        step_gain_q = '0;
        res_gain_q = '0;
        drive_gain_q = Q_ONE;
        clear_ladder();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == DIR_KNOWN_ROWS) begin
                drain_filter();
                set_filter(24'd4194304, 24'd4194304, 24'd1048576);
            end
            push_sample(dir_rows[r].sample, dir_rows[r].voice_rst,
                        dir_rows[r].known, dir_rows[r].outcome);
        end
        drain_filter();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_filter(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            sender_calm = (p == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
            receiver_calm = (p == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_sample(random_sample(), $urandom_range(0, 19) == 0, 1'b0, '0);
            end
            drain_filter();
        end

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
